### hw/rtl/bsl_pkg.sv
// shared types, codes and constants of the bounded shifting list
package bsl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CNT_W     = 5;
  localparam int OP_W      = 3;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 8;
  localparam int ST_W      = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  localparam logic signed [WORD_W-1:0] ERR_WORD = '1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] data_word;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count_out;
  } rsp_t;

  // outcome of the request checks
  typedef struct packed {
    logic             ins_ok;
    logic             rem_ok;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] at;
  } chk_t;

endpackage

### hw/rtl/bsl_check.sv
// request decode with full, empty and range checks
module bsl_check #(
  parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
  input  bsl_pkg::req_t                 req,
  input  logic [bsl_pkg::CNT_W-1:0]     count,
  input  logic [bsl_pkg::CNT_W-1:0]     cap,
  output bsl_pkg::chk_t                 chk
);
  import bsl_pkg::*;

  localparam int CW = 9;

  logic [CW-1:0] cap_w;
  logic [CW-1:0] eff_cap;
  logic [CW-1:0] cnt_w;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] at_w;
  logic          full;

  assign cap_w   = CW'(cap);
  assign eff_cap = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;
  assign cnt_w   = CW'(count);
  assign pos_w   = CW'(req.position);
  assign full    = (cnt_w >= eff_cap);

  always_comb begin
    chk    = '0;
    at_w   = '0;
    chk.status = ST_OK;
    unique case (req.operation) inside
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (req.operation == OP_PUSH_BACK) begin
          at_w = cnt_w;
        end else if (req.operation == OP_PUSH_FRONT) begin
          at_w = '0;
        end else begin
          at_w = pos_w;
        end
        if (full) begin
          chk.status = ST_FULL;
        end else if (at_w > cnt_w) begin
          chk.status = ST_RANGE;
        end else begin
          chk.ins_ok = 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
        if (req.operation == OP_POP_BACK) begin
          at_w = cnt_w - CW'(1);
        end else if (req.operation == OP_POP_FRONT) begin
          at_w = '0;
        end else begin
          at_w = pos_w;
        end
        if (cnt_w == '0) begin
          chk.status = ST_EMPTY;
        end else if (at_w >= cnt_w) begin
          chk.status = ST_RANGE;
        end else begin
          chk.rem_ok = 1'b1;
        end
      end
      default: begin
        chk.status = ST_OK;
      end
    endcase
    chk.at = at_w[POS_W-1:0];
  end

endmodule

### hw/rtl/bounded_shifting_list_top.sv
// top level of the bounded shifting list: sequencer around one entry memory
//
//  channel   direction  handshake                  payload
//  request   in         start / busy               in_req   (bsl_pkg::req_t)
//  result    out        out_valid strobe           out_rsp  (bsl_pkg::rsp_t)
//  capacity  in         cfg_we                     cfg_wdata (5 bits)
//
// a request transfers at a clock edge with start high and busy low
// errors and unused codes: result strobe the next cycle, busy stays low
// insert: S_UP moves each entry from the end down to the position one place up,
// then S_FLUSH and S_PUT write the word; an insert at the count goes straight to S_PUT;
// removal: S_GET reads the entry, then S_DOWN moves the later ones one place down;
// busy low again in the cycle of the strobe; shifts: one entry read and one written per cycle
// synchronous reset empties the list and sets capacity to 16; no clearing pass,
// the store is only ever read below the count
// the result strobe lasts one cycle and the receiver cannot stall it
module bounded_shifting_list_top #(
  parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  bsl_pkg::req_t             in_req,
  output logic                      out_valid,
  output bsl_pkg::rsp_t             out_rsp,
  input  logic                      cfg_we,
  input  logic [bsl_pkg::CNT_W-1:0] cfg_wdata
);
  import bsl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_GET   = 3'd4;
  localparam logic [2:0] S_DOWN  = 3'd5;

  logic [2:0]               state_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         cap_r;
  logic [CW-1:0]            cursor_r;
  logic [CW-1:0]            at_r;
  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] val_r;
  logic                     wpend_r;     // rdata_r waits to be written at waddr_r
  logic [AW-1:0]            waddr_r;
  logic                     val_pend_r;  // rdata_r holds the removed word
  logic                     out_valid_r;
  rsp_t                     out_r;

  // entry memory with registered read
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [WORD_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;

  logic                     accept;
  logic                     down_more;
  chk_t                     chk;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign down_more = (cursor_r < CW'(count_r));
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  bsl_check #(
    .DEPTH (DEPTH)
  ) u_check (
    .req   (in_req),
    .count (count_r),
    .cap   (cap_r),
    .chk   (chk)
  );

  // memory port steering: a pending shift write and the final word write
  // never fall into the same cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_r;
    mem_wdata = rdata_r;
    mem_re    = 1'b0;
    mem_raddr = cursor_r[AW-1:0];
    if (wpend_r) begin
      mem_we = 1'b1;
    end
    unique case (state_r)
      S_UP: begin
        mem_re = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = at_r[AW-1:0];
        mem_wdata = word_r;
      end
      S_GET: begin
        mem_re    = 1'b1;
        mem_raddr = at_r[AW-1:0];
      end
      S_DOWN: begin
        mem_re = down_more;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_req.data_word;
      at_r   <= CW'(chk.at);
    end
    if (val_pend_r) begin
      val_r <= rdata_r;
    end
    if (state_r == S_UP) begin
      waddr_r <= AW'(cursor_r + CW'(1));
    end else if (state_r == S_DOWN) begin
      waddr_r <= AW'(cursor_r - CW'(1));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      wpend_r     <= 1'b0;
      val_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          wpend_r     <= 1'b0;
          val_pend_r  <= 1'b0;
          out_valid_r <= accept && !chk.ins_ok && !chk.rem_ok;
          if (accept) begin
            if (chk.ins_ok) begin
              cursor_r <= CW'(count_r) - CW'(1);
              if (CW'(chk.at) == CW'(count_r)) begin
                state_r <= S_PUT;
              end else begin
                state_r <= S_UP;
              end
            end else if (chk.rem_ok) begin
              state_r <= S_GET;
            end else begin
              // error or unused code: answer at once
              out_r.status    <= chk.status;
              out_r.count_out <= count_r;
              out_r.value_out <= (chk.status != ST_OK) ? ERR_WORD : '0;
            end
          end
        end
        S_UP: begin
          // read entry at cursor, write it one place up next cycle
          wpend_r     <= 1'b1;
          val_pend_r  <= 1'b0;
          out_valid_r <= 1'b0;
          if (cursor_r == at_r) begin
            state_r <= S_FLUSH;
          end else begin
            cursor_r <= cursor_r - CW'(1);
          end
        end
        S_FLUSH: begin
          wpend_r     <= 1'b0;
          val_pend_r  <= 1'b0;
          out_valid_r <= 1'b0;
          state_r     <= S_PUT;
        end
        S_PUT: begin
          wpend_r         <= 1'b0;
          val_pend_r      <= 1'b0;
          count_r         <= count_r + CNT_W'(1);
          out_valid_r     <= 1'b1;
          out_r.status    <= ST_OK;
          out_r.count_out <= count_r + CNT_W'(1);
          out_r.value_out <= '0;
          state_r         <= S_IDLE;
        end
        S_GET: begin
          wpend_r     <= 1'b0;
          val_pend_r  <= 1'b1;
          out_valid_r <= 1'b0;
          cursor_r    <= at_r + CW'(1);
          state_r     <= S_DOWN;
        end
        S_DOWN: begin
          // read entry at cursor, write it one place down next cycle
          wpend_r     <= down_more;
          val_pend_r  <= 1'b0;
          out_valid_r <= !down_more;
          if (down_more) begin
            cursor_r <= cursor_r + CW'(1);
          end else begin
            count_r         <= count_r - CNT_W'(1);
            out_r.status    <= ST_OK;
            out_r.count_out <= count_r - CNT_W'(1);
            out_r.value_out <= val_pend_r ? rdata_r : val_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          wpend_r     <= 1'b0;
          val_pend_r  <= 1'b0;
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  // the count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(DEPTH))
    else $error("entry count beyond store depth");

  // a rejected or unused request answers in the next cycle without going busy
  a_err_fast: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !chk.ins_ok && !chk.rem_ok |=> out_valid && !busy)
    else $error("rejected request not answered next cycle");

  // read data is claimed by at most one consumer
  a_rdata_one_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(wpend_r && val_pend_r))
    else $error("read data claimed twice");

  // the word write never collides with a pending shift write
  a_put_port: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> !wpend_r)
    else $error("write port collision");

  // busy is always low while a result strobe is high
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

endmodule

### sim/testbench.sv
// self-checking testbench for the bounded shifting list: directed and random requests
`timescale 1ns / 100ps

module testbench;
  import bsl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int HALF_PERIOD = 4;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 4;   // worst-case shift plus margin
  localparam int WATCHDOG_LIMIT = 1000;            // longest gap + settle + shift, several times
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 148;
  localparam int SEGMENT_ITEMS = 24;

  // the two operation codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // one pending stimulus entry: a request or a capacity write
  typedef struct {
    logic             is_cap_write;
    req_t             req;
    logic [CNT_W-1:0] cap;
    int               gap;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start = 1'b0;
  logic             busy;
  req_t             in_req = '0;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = CAP_RESET;

  pending_t pending_q[$];
  rsp_t     rsp_due_q[$];

  // shadow copy of the list, its count and the capacity register
  logic signed [WORD_W-1:0] list_mem [LIST_DEPTH] = '{default: '0};
  int                       list_cnt = 0;
  logic [CNT_W-1:0]         cap_model = CAP_RESET;

  logic req_fire = 1'b0;      // request transfer seen at the last rising edge
  int   err_count = 0;
  int   idle_cycles = 0;
  int   gap_left = 0;
  logic gap_armed = 1'b0;
  int   settle_left = SETTLE_CYCLES;

  bounded_shifting_list_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // expected answer of one request, applied to the shadow list
  // ---------------------------------------------------------------------------
  task predict_list_op(input req_t r, output rsp_t rsp);
    int eff_cap;
    int at;
    int i;
    logic signed [WORD_W-1:0] val;
    logic [ST_W-1:0] st;
    begin
      eff_cap = (int'(cap_model) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_model);
      val = '0;
      st = ST_OK;
      case (r.operation)
        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
          // full check wins over the position check
          if (list_cnt >= eff_cap) begin
            st = ST_FULL;
          end else begin
            if (r.operation == OP_PUSH_BACK) at = list_cnt;
            else if (r.operation == OP_PUSH_FRONT) at = 0;
            else at = int'(r.position);
            if (at > list_cnt || at >= LIST_DEPTH) begin
              st = ST_RANGE;
            end else begin
              // open a gap: later entries move up by one
              for (i = list_cnt; i > at; i--) begin
                if (i < LIST_DEPTH) list_mem[i] = list_mem[i-1];
              end
              list_mem[at] = r.data_word;
              list_cnt++;
            end
          end
        end
        OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
          // empty check wins over the position check
          if (list_cnt == 0) begin
            st = ST_EMPTY;
          end else begin
            if (r.operation == OP_POP_BACK) at = list_cnt - 1;
            else if (r.operation == OP_POP_FRONT) at = 0;
            else at = int'(r.position);
            if (at >= list_cnt || at >= LIST_DEPTH) begin
              st = ST_RANGE;
            end else begin
              val = list_mem[at];
              // close the gap: later entries move down by one
              for (i = at + 1; i < list_cnt && i < LIST_DEPTH; i++) begin
                list_mem[i-1] = list_mem[i];
              end
              list_cnt--;
            end
          end
        end
        default: begin
          // unused codes leave everything alone and answer ok
        end
      endcase
      if (st != ST_OK) val = ERR_WORD;
      rsp.value_out = val;
      rsp.status = st;
      rsp.count_out = CNT_W'(list_cnt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task queue_request(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] word,
                     input logic [POS_W-1:0] pos, input int gap);
    pending_t p;
    begin
      p.is_cap_write = 1'b0;
      p.req.operation = op;
      p.req.data_word = word;
      p.req.position = pos;
      p.cap = '0;
      p.gap = gap;
      pending_q.insert(pending_q.size(), p);
    end
  endtask

  task queue_capacity(input logic [CNT_W-1:0] value);
    pending_t p;
    begin
      p.is_cap_write = 1'b1;
      p.req = '0;
      p.cap = value;
      p.gap = 0;
      pending_q.insert(pending_q.size(), p);
    end
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(input logic quiet);
    int r;
    begin
      r = $urandom_range(0, 99);
      if (quiet || r < 55) pick_gap = 0;
      else if (r < 85) pick_gap = $urandom_range(1, 3);
      else if (r < 97) pick_gap = $urandom_range(4, 15);
      else pick_gap = $urandom_range(20, 40);
    end
  endfunction

  // growing segments push the list to full, shrinking ones drain it
  function automatic logic [OP_W-1:0] pick_op(input logic growing);
    int r;
    logic grow;
    begin
      r = $urandom_range(0, 99);
      grow = growing ? (r < 82) : (r < 15);
      if (r >= 96) begin
        pick_op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else if (grow) begin
        case ($urandom_range(0, 2))
          0: pick_op = OP_PUSH_BACK;
          1: pick_op = OP_PUSH_FRONT;
          default: pick_op = OP_INSERT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: pick_op = OP_POP_BACK;
          1: pick_op = OP_POP_FRONT;
          default: pick_op = OP_REMOVE;
        endcase
      end
    end
  endfunction

  task build_stimulus;
    logic [CNT_W-1:0] phase_cap [7];
    logic growing;
    logic quiet;
    logic [POS_W-1:0] pos;
    int ph;
    int n;
    begin
      phase_cap = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd15, 5'd8};

      // directed: empty list, reset capacity of 16
      queue_request(OP_POP_BACK, 32'sd5, 8'd0, 0);
      queue_request(OP_POP_FRONT, 32'sd5, 8'd0, 0);
      queue_request(OP_REMOVE, 32'sd5, 8'd255, 0);        // empty beats range
      queue_request(OP_PUSH_BACK, 32'sh7fffffff, 8'd0, 0);
      queue_request(OP_PUSH_FRONT, 32'sh80000000, 8'd0, 1);
      queue_request(OP_INSERT, -32'sd1, 8'd1, 0);
      queue_request(OP_INSERT, 32'sd0, 8'd3, 0);          // position equal to count
      queue_request(OP_INSERT, 32'sd9, 8'd5, 0);          // beyond count
      queue_request(OP_INSERT, 32'sd9, 8'd255, 2);
      queue_request(OP_REMOVE, 32'sd0, 8'd4, 0);          // position equal to count
      queue_request(OP_REMOVE, 32'sd0, 8'd255, 0);
      queue_request(OP_REMOVE, 32'sd0, 8'd1, 0);
      queue_request(OP_SPARE_LO, 32'sh5a5a5a5a, 8'haa, 0);
      queue_request(OP_SPARE_HI, 32'sha5a5a5a5, 8'h55, 0);
      // capacity dropped below the count: full, but pops still work
      queue_capacity(5'd2);
      queue_request(OP_PUSH_BACK, 32'sd11, 8'd0, 0);
      queue_request(OP_INSERT, 32'sd12, 8'd255, 0);       // full beats range
      queue_request(OP_POP_FRONT, 32'sd0, 8'd0, 0);
      queue_request(OP_POP_BACK, 32'sd0, 8'd0, 0);
      // capacity of zero refuses every push
      queue_capacity(5'd0);
      queue_request(OP_PUSH_FRONT, 32'sd13, 8'd0, 0);
      queue_request(OP_INSERT, 32'sd14, 8'd0, 0);
      queue_request(OP_REMOVE, 32'sd0, 8'd0, 0);

      // random phases, each under its own capacity
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
        queue_capacity(ph < 7 ? phase_cap[ph] : CNT_W'($urandom_range(0, 31)));
        quiet = ($urandom_range(0, 3) == 0);
        growing = 1'($urandom_range(0, 1));
        for (n = 0; n < PHASE_ITEMS; n++) begin
          if (n % SEGMENT_ITEMS == 0) growing = ~growing;
          pos = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, LIST_DEPTH + 1))
                                             : POS_W'($urandom_range(0, 255));
          queue_request(pick_op(growing), WORD_W'($urandom), pos, pick_gap(quiet));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_blk
    logic             nx_start;
    req_t             nx_req;
    logic             nx_we;
    logic [CNT_W-1:0] nx_wdata;
    nx_start = start;
    nx_req = in_req;
    nx_we = 1'b0;
    nx_wdata = cfg_wdata;
    if (rst_n) begin
      // start stays up until the request transfers
      if (!start || req_fire) begin
        nx_start = 1'b0;
        if (pending_q.size() != 0) begin
          if (pending_q[0].is_cap_write) begin
            // capacity only changes with the block idle and nothing outstanding
            if (start || busy || rsp_due_q.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
              settle_left--;
            end else begin
              nx_we = 1'b1;
              nx_wdata = pending_q[0].cap;
              pending_q.delete(0);
              settle_left = SETTLE_CYCLES;
            end
          end else begin
            if (!gap_armed) begin
              gap_left = pending_q[0].gap;
              gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nx_req = pending_q[0].req;
              nx_start = 1'b1;
              pending_q.delete(0);
              gap_armed = 1'b0;
            end
          end
        end
      end
    end
    start <= nx_start;
    in_req <= nx_req;
    cfg_we <= nx_we;
    cfg_wdata <= nx_wdata;
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_blk
    rsp_t exp_rsp;
    rsp_t new_rsp;
    logic bad;
    if (rst_n) begin
      req_fire = start && !busy;

      if (cfg_we) cap_model = cfg_wdata;

      // results first: a result at this edge belongs to an older request
      if (out_valid) begin
        if (rsp_due_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: value %0d status %0d count %0d",
                     $realtime, out_rsp.value_out, out_rsp.status, out_rsp.count_out);
        end else begin
          exp_rsp = rsp_due_q[0];
          rsp_due_q.delete(0);
          bad = (out_rsp.value_out !== exp_rsp.value_out) ||
                (out_rsp.status !== exp_rsp.status) ||
                (out_rsp.count_out !== exp_rsp.count_out);
          if (bad) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: result mismatch: value %0d/%0d status %0d/%0d count %0d/%0d",
                       $realtime, exp_rsp.value_out, out_rsp.value_out,
                       exp_rsp.status, out_rsp.status, exp_rsp.count_out, out_rsp.count_out);
          end
        end
      end

      if (req_fire) begin
        predict_list_op(in_req, new_rsp);
        rsp_due_q.insert(rsp_due_q.size(), new_rsp);
      end

      // watchdog on cycles without any transfer
      if (req_fire || out_valid || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[bounded_shifting_list_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control: reset once, feed the driver, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    build_stimulus();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for every request to transfer and every answer to come back
    while (pending_q.size() != 0 || start || rsp_due_q.size() != 0) @(negedge clk);
    // let any stray strobe show up
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (err_count == 0 && rsp_due_q.size() == 0) begin
      $display("[bounded_shifting_list_top] OK");
    end else begin
      $display("[bounded_shifting_list_top] ERROR");
    end
    $finish;
  end

endmodule
